// File: src/acd_pkg.sv
// Shared types and constants for the amount compress/decompress block.
// Used by acd_div, amount_compress_decompress and acd_checker; no dependencies.
package acd_pkg;

	localparam int unsigned VAL_W = 64;
	localparam int unsigned DIG_W = 4;
	localparam logic [DIG_W-1:0] TEN = 4'd10;
	localparam logic [DIG_W-1:0] NINE = 4'd9;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CCHK,
		ST_CWAIT,
		ST_CMUL9,
		ST_CADDD,
		ST_P9,
		ST_MUL10,
		ST_ADDE,
		ST_DSUB,
		ST_DDIV10,
		ST_DWAIT10,
		ST_DDIV9,
		ST_DWAIT9,
		ST_DADDD,
		ST_DINC,
		ST_DEXP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic by_nine;
		logic [VAL_W-1:0] operand;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [VAL_W-1:0] quotient;
		logic [DIG_W-1:0] remainder;
	} div_rsp_t;

endpackage

// File: src/acd_div.sv
// Divider by nine or ten through a reciprocal multiplication, one 32 by 32 partial
// product per cycle; done flags the quotient and remainder once the last partial product is summed.
// Depends on acd_pkg for the request and response types.
module acd_div (
	input  logic              clk,
	input  logic              arst_n,
	input  acd_pkg::div_req_t req,
	output acd_pkg::div_rsp_t rsp
);

	localparam int unsigned HALF_W = acd_pkg::VAL_W / 2;
	localparam int unsigned PROD_W = 2 * acd_pkg::VAL_W;
	localparam int unsigned RECIP_SHIFT = 67;
	localparam logic [acd_pkg::VAL_W-1:0] RECIP_TEN = 64'hCCCC_CCCC_CCCC_CCCD;
	localparam logic [acd_pkg::VAL_W-1:0] RECIP_NINE = 64'hE38E_38E3_8E38_E38F;

	typedef logic [acd_pkg::VAL_W-1:0] word_t;
	typedef logic [PROD_W-1:0] dword_t;

	logic [acd_pkg::VAL_W-1:0] num_q;
	logic [acd_pkg::VAL_W-1:0] recip_q;
	logic [acd_pkg::DIG_W-1:0] dv_q;
	logic [PROD_W-1:0]         acc_q;
	logic [1:0]                step_q;
	logic                      busy_q;
	logic                      done_q;
	logic [HALF_W-1:0]         mul_a;
	logic [HALF_W-1:0]         mul_b;
	logic [acd_pkg::VAL_W-1:0] prod;
	logic [PROD_W-1:0]         prod_ext;
	logic [acd_pkg::VAL_W-1:0] quo;
	logic [acd_pkg::DIG_W-1:0] rem;

	// The quotient is the top of the product with the rounded-up reciprocal, which is exact
	// for every 64-bit dividend; the remainder fits in four bits, so only the low bits count.
	always_comb begin
		mul_a = step_q[0] ? num_q[acd_pkg::VAL_W-1:HALF_W] : num_q[HALF_W-1:0];
		mul_b = step_q[1] ? recip_q[acd_pkg::VAL_W-1:HALF_W] : recip_q[HALF_W-1:0];
		prod = word_t'(mul_a) * word_t'(mul_b);
		case (step_q)
			2'd0: prod_ext = dword_t'(prod);
			2'd3: prod_ext = {prod, word_t'(0)};
			default: prod_ext = dword_t'(prod) << HALF_W;
		endcase
		quo = word_t'(acc_q >> RECIP_SHIFT);
		rem = num_q[acd_pkg::DIG_W-1:0] - quo[acd_pkg::DIG_W-1:0] * dv_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.operand;
			recip_q <= req.by_nine ? RECIP_NINE : RECIP_TEN;
			dv_q <= req.by_nine ? acd_pkg::NINE : acd_pkg::TEN;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + prod_ext;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo;
	assign rsp.remainder = rem;

endmodule

// File: src/amount_compress_decompress.sv
// Top level: decimal amount compression and its inverse on one shared adder and a divider.
// A zero value goes straight to the result; compress runs one to nine divisions,
// and the length of an expand is set by the decimal exponent.
// Throughput: one transfer at a time; the next is accepted as the result appears.
// Reset: arst_n clears the sequencer and the output valid flag asynchronously.
// Depends on acd_pkg and acd_div.
module amount_compress_decompress (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [acd_pkg::VAL_W-1:0] s_tdata,  // [63:0] value
	input  logic                      s_tuser,  // [0] operation
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [acd_pkg::VAL_W-1:0] m_tdata   // [63:0] result
);

	acd_pkg::state_t           state_q, state_d;
	logic [acd_pkg::VAL_W-1:0] acc_q, acc_d;
	logic [acd_pkg::DIG_W-1:0] e_q, e_d;
	logic [acd_pkg::DIG_W-1:0] d_q, d_d;
	logic                      op_q, op_d;
	logic [acd_pkg::VAL_W-1:0] out_q;
	logic                      out_valid_q, out_valid_d;
	logic                      out_load;
	logic [acd_pkg::VAL_W-1:0] add_a, add_b, sum;
	acd_pkg::div_req_t         div_req;
	acd_pkg::div_rsp_t         div_rsp;

	acd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign sum = add_a + add_b;

	always_comb begin
		state_d = state_q;
		acc_d = acc_q;
		e_d = e_q;
		d_d = d_q;
		op_d = op_q;
		out_load = 1'b0;
		out_valid_d = out_valid_q && !m_tready;
		add_a = acc_q;
		add_b = '0;
		div_req.start = 1'b0;
		div_req.by_nine = 1'b0;
		div_req.operand = acc_q;
		s_tready = 1'b0;
		case (state_q)
			acd_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					acc_d = s_tdata;
					op_d = s_tuser;
					e_d = '0;
					if (s_tdata == '0) begin
						state_d = acd_pkg::ST_DONE;
					end else if (s_tuser) begin
						state_d = acd_pkg::ST_DSUB;
					end else begin
						state_d = acd_pkg::ST_CCHK;
					end
				end
			end
			acd_pkg::ST_CCHK: begin
				if (e_q == acd_pkg::NINE) begin
					state_d = acd_pkg::ST_P9;
				end else begin
					div_req.start = 1'b1;
					state_d = acd_pkg::ST_CWAIT;
				end
			end
			acd_pkg::ST_CWAIT: begin
				if (div_rsp.done) begin
					acc_d = div_rsp.quotient;
					if (div_rsp.remainder == '0) begin
						e_d = e_q + 4'd1;
						state_d = acd_pkg::ST_CCHK;
					end else begin
						d_d = div_rsp.remainder;
						state_d = acd_pkg::ST_CMUL9;
					end
				end
			end
			acd_pkg::ST_CMUL9: begin
				add_a = {acc_q[acd_pkg::VAL_W-4:0], 3'b000};
				add_b = acc_q;
				acc_d = sum;
				state_d = acd_pkg::ST_CADDD;
			end
			acd_pkg::ST_CADDD: begin
				add_b = {60'd0, d_q - 4'd1};
				acc_d = sum;
				state_d = acd_pkg::ST_MUL10;
			end
			acd_pkg::ST_P9: begin
				add_b = '1;
				acc_d = sum;
				state_d = acd_pkg::ST_MUL10;
			end
			acd_pkg::ST_MUL10: begin
				add_a = {acc_q[acd_pkg::VAL_W-4:0], 3'b000};
				add_b = {acc_q[acd_pkg::VAL_W-2:0], 1'b0};
				acc_d = sum;
				state_d = op_q ? acd_pkg::ST_DADDD : acd_pkg::ST_ADDE;
			end
			acd_pkg::ST_ADDE: begin
				add_b = {60'd0, e_q + 4'd1};
				acc_d = sum;
				state_d = acd_pkg::ST_DONE;
			end
			acd_pkg::ST_DSUB: begin
				add_b = '1;
				acc_d = sum;
				state_d = acd_pkg::ST_DDIV10;
			end
			acd_pkg::ST_DDIV10: begin
				div_req.start = 1'b1;
				state_d = acd_pkg::ST_DWAIT10;
			end
			acd_pkg::ST_DWAIT10: begin
				if (div_rsp.done) begin
					acc_d = div_rsp.quotient;
					e_d = div_rsp.remainder;
					if (div_rsp.remainder == acd_pkg::NINE) begin
						state_d = acd_pkg::ST_DINC;
					end else begin
						state_d = acd_pkg::ST_DDIV9;
					end
				end
			end
			acd_pkg::ST_DDIV9: begin
				div_req.start = 1'b1;
				div_req.by_nine = 1'b1;
				state_d = acd_pkg::ST_DWAIT9;
			end
			acd_pkg::ST_DWAIT9: begin
				if (div_rsp.done) begin
					acc_d = div_rsp.quotient;
					d_d = div_rsp.remainder + 4'd1;
					state_d = acd_pkg::ST_MUL10;
				end
			end
			acd_pkg::ST_DADDD: begin
				add_b = {60'd0, d_q};
				acc_d = sum;
				state_d = acd_pkg::ST_DEXP;
			end
			acd_pkg::ST_DINC: begin
				add_b = 64'd1;
				acc_d = sum;
				state_d = acd_pkg::ST_DEXP;
			end
			acd_pkg::ST_DEXP: begin
				if (e_q == '0) begin
					state_d = acd_pkg::ST_DONE;
				end else begin
					add_a = {acc_q[acd_pkg::VAL_W-4:0], 3'b000};
					add_b = {acc_q[acd_pkg::VAL_W-2:0], 1'b0};
					acc_d = sum;
					e_d = e_q - 4'd1;
				end
			end
			acd_pkg::ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					out_valid_d = 1'b1;
					state_d = acd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = acd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= acd_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		acc_q <= acc_d;
		e_q <= e_d;
		d_q <= d_d;
		op_q <= op_d;
		if (out_load) begin
			out_q <= acc_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_q;

endmodule

// File: src/acd_checker.sv
// Port-level assertions for amount_compress_decompress, attached by bind.
// Depends on acd_pkg for the data width.
module acd_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic [acd_pkg::VAL_W-1:0] s_tdata,
	input logic                      s_tuser,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [acd_pkg::VAL_W-1:0] m_tdata
);

	// A result that is not taken stays in place.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// The block works on one transfer at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while busy");

	// A new result appears only as the sequencer returns to idle.
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result raised while busy");

	// Reset holds the output channel empty.
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("result valid during reset");

	// An offered request carries known fields.
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid |-> !$isunknown({s_tuser, s_tdata}))
		else $error("unknown request fields");

endmodule

bind amount_compress_decompress acd_checker u_acd_checker (.*);

// File: tb/sv/amount_compress_decompress_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for amount_compress_decompress: compress and expand requests
// go in as stream transfers, and every result is checked against a behavioral predictor.
// Depends on acd_pkg and the amount_compress_decompress RTL.
module amount_compress_decompress_test;

	localparam int unsigned VAL_W = acd_pkg::VAL_W;
	localparam logic OP_COMPRESS = 1'b0;
	localparam logic OP_EXPAND = 1'b1;
	localparam int unsigned QUIET_LIMIT = 5000;
	localparam int unsigned DRAIN_CYCLES = 300;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned RANDOM_PER_PHASE = 257;

	typedef struct {
		logic op;
		logic [VAL_W-1:0] value;
	} request_t;

	typedef struct {
		logic op;
		logic [VAL_W-1:0] value;
		logic [VAL_W-1:0] result;
	} expected_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [VAL_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [VAL_W-1:0] m_tdata;

	request_t pending_requests[$];
	expected_t expected_results[$];
	int unsigned queued_count = 0;
	int unsigned sent_count = 0;
	int unsigned error_count = 0;
	int unsigned send_gap_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_id = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned quiet_cycles = 0;

	amount_compress_decompress uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	function automatic logic [VAL_W-1:0] pack_amount(logic [VAL_W-1:0] amount);
		logic [VAL_W-1:0] n;
		logic [VAL_W-1:0] digit;
		logic [VAL_W-1:0] zeros;
		n = amount;
		zeros = '0;
		if (n == '0) begin
			return '0;
		end
		while (n % 10 == 0 && zeros < 9) begin
			n = n / 10;
			zeros = zeros + 1;
		end
		if (zeros < 9) begin
			digit = n % 10;
			n = n / 10;
			return 1 + (n * 9 + digit - 1) * 10 + zeros;
		end
		return 1 + (n - 1) * 10 + 9;
	endfunction

	function automatic logic [VAL_W-1:0] expand_code(logic [VAL_W-1:0] code);
		logic [VAL_W-1:0] x;
		logic [VAL_W-1:0] n;
		logic [VAL_W-1:0] digit;
		logic [VAL_W-1:0] zeros;
		if (code == '0) begin
			return '0;
		end
		x = code - 1;
		zeros = x % 10;
		x = x / 10;
		if (zeros < 9) begin
			digit = x % 9 + 1;
			x = x / 9;
			n = x * 10 + digit;
		end else begin
			n = x + 1;
		end
		while (zeros != 0) begin
			n = n * 10;
			zeros = zeros - 1;
		end
		return n;
	endfunction

	function automatic logic [VAL_W-1:0] random_wide();
		return {$urandom, $urandom};
	endfunction

	function automatic void queue_request(logic op, logic [VAL_W-1:0] value);
		request_t item;
		item.op = op;
		item.value = value;
		pending_requests.push_back(item);
		queued_count++;
	endfunction

	task automatic report_mismatch(string what, logic op, logic [VAL_W-1:0] value,
			logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
		$display("%0t: %s: op=%0d value=%0d got=%0d expected=%0d",
			$time, what, op, value, got, want);
		error_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		request_t item;
		expected_t entry;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= OP_COMPRESS;
		end else begin
			if (s_tvalid && s_tready) begin
				entry.op = s_tuser;
				entry.value = s_tdata;
				entry.result = (s_tuser == OP_COMPRESS) ? pack_amount(s_tdata)
					: expand_code(s_tdata);
				expected_results.push_back(entry);
				sent_count++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_requests.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
					item = pending_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= item.op;
					s_tdata <= item.value;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_seen <= 0;
			hold_left <= 0;
		end else if (hold_id != hold_seen) begin
			hold_seen <= hold_id;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		expected_t oldest;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing expected", OP_COMPRESS, '0, m_tdata, '0);
			end else begin
				oldest = expected_results.pop_front();
				if (m_tdata !== oldest.result) begin
					report_mismatch("wrong result", oldest.op, oldest.value, m_tdata,
						oldest.result);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL amount_compress_decompress");
			$finish;
		end
	end

	initial begin
		logic [VAL_W-1:0] amount;
		int unsigned kind;
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		queue_request(OP_COMPRESS, 64'd0);
		queue_request(OP_COMPRESS, 64'd1);
		queue_request(OP_COMPRESS, 64'd9);
		queue_request(OP_COMPRESS, 64'd10);
		queue_request(OP_COMPRESS, 64'd123456789);
		queue_request(OP_COMPRESS, 64'd100000000);
		queue_request(OP_COMPRESS, 64'd1000000000);
		queue_request(OP_COMPRESS, 64'd50000000000);
		queue_request(OP_COMPRESS, 64'd10000000000000000000);
		queue_request(OP_COMPRESS, 64'd18446744073709551610);
		queue_request(OP_COMPRESS, 64'h8000_0000_0000_0000);
		queue_request(OP_COMPRESS, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_request(OP_EXPAND, 64'd0);
		queue_request(OP_EXPAND, 64'd1);
		queue_request(OP_EXPAND, 64'd2);
		queue_request(OP_EXPAND, 64'd9);
		queue_request(OP_EXPAND, 64'd10);
		queue_request(OP_EXPAND, 64'd11);
		queue_request(OP_EXPAND, pack_amount(64'd2100000000000000));
		queue_request(OP_EXPAND, 64'hFFFF_FFFF_FFFF_FFF0);
		queue_request(OP_EXPAND, 64'hFFFF_FFFF_FFFF_FFFF);
		wait (sent_count == queued_count && expected_results.size() == 0);

		for (int phase = 0; phase < 4; phase++) begin
			send_gap_pct = (phase == 1) ? 50 : (phase == 3) ? 21 : 0;
			stall_pct = (phase == 2) ? 50 : (phase == 3) ? 21 : 0;
			// A long receiver hold-off while requests keep coming backs up the block.
			if (phase == 0) begin
				hold_id++;
			end
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				amount = random_wide() >> $urandom_range(63);
				repeat ($urandom_range(12)) amount = amount * 10;
				kind = $urandom_range(9);
				if (kind <= 2) begin
					queue_request(OP_COMPRESS, amount);
				end else if (kind == 3) begin
					queue_request(OP_COMPRESS, random_wide());
				end else if (kind <= 6) begin
					queue_request(OP_EXPAND, pack_amount(amount));
				end else if (kind == 7) begin
					queue_request(OP_EXPAND, 64'($urandom_range(2000)));
				end else if (kind == 8) begin
					queue_request(OP_EXPAND, random_wide());
				end else begin
					queue_request(1'($urandom_range(1)), random_wide() >> $urandom_range(63));
				end
			end
			wait (sent_count == queued_count && expected_results.size() == 0);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("PASS amount_compress_decompress");
		end else begin
			$display("FAIL amount_compress_decompress");
		end
		$finish;
	end

endmodule

// File: filelist.f
src/acd_pkg.sv
src/acd_div.sv
src/amount_compress_decompress.sv
src/acd_checker.sv
tb/sv/amount_compress_decompress_test.sv
